[rtl/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// Media clock rescaler package
// Shared payload types, command codes, datapath commands and constants.
// ----------------------------------------------------------------------------
package mcr_pkg;

   // Query kinds.
   localparam logic [2:0] CMD_SLOT_AT   = 3'd0;
   localparam logic [2:0] CMD_SAMPLE_AT = 3'd1;
   localparam logic [2:0] CMD_START     = 3'd2;
   localparam logic [2:0] CMD_DEADLINE  = 3'd3;
   localparam logic [2:0] CMD_RANGE     = 3'd4;

   // Register indexes.
   localparam logic [1:0] REG_ANCHOR = 2'd0;
   localparam logic [1:0] REG_NUM    = 2'd1;
   localparam logic [1:0] REG_DEN    = 2'd2;
   localparam logic [1:0] REG_AUDIO  = 2'd3;

   localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
   localparam logic [63:0] I64_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] query_value;
      logic [1:0]  buffer_frames;
   } req_type;

   typedef struct packed {
      logic [63:0] answer;
      logic [62:0] sample_count;
      logic        status;
   } rsp_type;

   // Operation selected for one multiply-divide pass.
   typedef enum logic [2:0] {
      OP_SLOT_AT   = 3'b001,
      OP_SAMPLE_AT = 3'b010,
      OP_START     = 3'b100
   } op_type;

   // Controller to datapath.
   typedef struct packed {
      logic   load;      // capture query
      logic   start;     // launch one conversion
      op_type op;
      logic   use_b;     // saved start: 0 a, 1 b, when src_start is set
      logic [1:0] slot_add; // slot offset added to query value
      logic   src_start; // sample_at source: 0 query, 1 saved start a or b
      logic   save_a;    // keep result as start a
      logic   save_b;    // keep result as start b
      logic   save_fst;  // keep result as first sample
      logic   finish;    // build response
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic busy;
      logic ok;          // last conversion produced an answer
   } dp_sts_type;

endpackage

[rtl/mcr_datapath.sv]
// ----------------------------------------------------------------------------
// Media clock rescaler datapath
// Configuration registers, operand setup, a 32x32 multiplier stepped over
// four partial products, and a radix-2 divider of 64 steps.
// ----------------------------------------------------------------------------
module mcr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_data,
   input  mcr_pkg::req_type    req_data,
   input  mcr_pkg::dp_cmd_type cmd,
   output mcr_pkg::dp_sts_type sts,
   output mcr_pkg::rsp_type    rsp_value
);

   typedef enum logic [3:0] {
      U_IDLE = 4'b0001,
      U_MUL  = 4'b0010,
      U_DIV  = 4'b0100,
      U_POST = 4'b1000
   } unit_type;

   logic [62:0] anchor_ff;
   logic [19:0] num_ff, den_ff, audio_ff;
   mcr_pkg::req_type q_ff;
   logic [63:0] a_ff, b_ff, fst_ff, res_ff;
   logic        ok_ff, bad_ff;
   unit_type    unit_ff, unit_in;
   mcr_pkg::op_type op_ff;
   logic        early_ff;     // result already settled without division
   logic [63:0] early_val_ff;
   logic [63:0] ma_ff, mb_ff, d_ff;
   logic [127:0] prod_ff;
   logic [1:0]  pp_ff;
   logic [6:0]  step_ff;
   logic [63:0] rem_ff, lo_ff, quo_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff <= '0;
         num_ff    <= 20'd30;
         den_ff    <= 20'd1;
         audio_ff  <= 20'd48000;
      end else if (csr_valid) begin
         unique case (csr_index)
            mcr_pkg::REG_ANCHOR: anchor_ff <= csr_data[62:0];
            mcr_pkg::REG_NUM:    num_ff    <= csr_data[19:0];
            mcr_pkg::REG_DEN:    den_ff    <= csr_data[19:0];
            mcr_pkg::REG_AUDIO:  audio_ff  <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   // Operand setup for the requested conversion.
   logic [63:0] slot_v, t_v, anc64, ns_den;
   logic        slot_carry, start_neg;
   assign anc64  = {1'b0, anchor_ff};
   assign ns_den = 64'(mcr_pkg::NS_PER_SEC[31:0] * {12'd0, den_ff});
   assign {slot_carry, slot_v} = {1'b0, q_ff.query_value} + {63'd0, cmd.slot_add};
   assign t_v       = cmd.src_start ? (cmd.use_b ? b_ff : a_ff) : q_ff.query_value;
   assign start_neg = q_ff.query_value[63] ||
                      (slot_v > mcr_pkg::I64_MAX);

   // One partial product of 32x32 bits per cycle.
   logic [31:0] pa, pb;
   logic [63:0] pp;
   always_comb begin
      pa = pp_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      pb = pp_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      pp = pa * pb;
   end

   // Divider step.
   logic [64:0] shl;
   logic        take;
   assign shl  = {rem_ff, lo_ff[63]};
   assign take = shl[64] || (shl[63:0] >= d_ff);

   // Post-processing of the quotient.
   logic [63:0] up;
   logic        up_c;
   assign {up_c, up} = {1'b0, quo_ff} + {64'd0, (rem_ff != 0)};

   always_comb begin
      unit_in = unit_ff;
      unique case (unit_ff)
         U_IDLE: if (cmd.start) unit_in = U_MUL;
         U_MUL:  if (pp_ff == 2'd3) unit_in = early_ff ? U_POST : U_DIV;
         U_DIV:  if (step_ff == 7'd63) unit_in = U_POST;
         U_POST: unit_in = U_IDLE;
         default: unit_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= U_IDLE;
      end else begin
         unit_ff <= unit_in;
      end
   end

   // Conversion sequence.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_ff   <= req_data;
         bad_ff <= 1'b0;
      end
      unique case (unit_ff)
         U_IDLE: if (cmd.start) begin
            op_ff    <= cmd.op;
            pp_ff    <= 2'd0;
            prod_ff  <= '0;
            early_ff <= 1'b0;
            early_val_ff <= '0;
            if (cmd.op == mcr_pkg::OP_START) begin
               ma_ff <= slot_v;
               mb_ff <= ns_den;
               d_ff  <= {44'd0, num_ff};
               if (start_neg || slot_carry) begin
                  early_ff <= 1'b1;
                  early_val_ff <= 64'd1; // flags failure
               end
            end else begin
               ma_ff <= t_v - anc64;
               mb_ff <= (cmd.op == mcr_pkg::OP_SLOT_AT) ? {44'd0, num_ff}
                                                        : {44'd0, audio_ff};
               d_ff  <= (cmd.op == mcr_pkg::OP_SLOT_AT) ? ns_den : mcr_pkg::NS_PER_SEC;
               if (t_v[63] || t_v < anc64) begin
                  early_ff <= 1'b1;
                  early_val_ff <= '1;
               end else if (t_v == anc64) begin
                  early_ff <= 1'b1;
                  early_val_ff <= '0;
               end
            end
         end
         U_MUL: begin
            prod_ff <= prod_ff +
                       ({64'd0, pp} << {({1'b0, pp_ff[1]} + {1'b0, pp_ff[0]}), 5'd0});
            pp_ff   <= pp_ff + 2'd1;
            rem_ff  <= '0;
            step_ff <= '0;
            quo_ff  <= '0;
         end
         U_DIV: begin
            if (step_ff == 7'd0) begin
               // first step starts from the high half of the product
               lo_ff  <= {prod_ff[62:0], 1'b0};
               begin : first
                  logic [64:0] s0;
                  logic        t0;
                  s0 = {prod_ff[127:64], prod_ff[63]};
                  t0 = s0[64] || (s0[63:0] >= d_ff);
                  rem_ff <= t0 ? s0[63:0] - d_ff : s0[63:0];
                  quo_ff <= {63'd0, t0};
               end
            end else begin
               lo_ff  <= {lo_ff[62:0], 1'b0};
               rem_ff <= take ? shl[63:0] - d_ff : shl[63:0];
               quo_ff <= {quo_ff[62:0], take};
            end
            step_ff <= step_ff + 7'd1;
         end
         U_POST: begin
            if (op_ff == mcr_pkg::OP_START) begin
               if (early_ff || d_ff == 64'd0 || prod_ff[127:64] >= d_ff || up_c ||
                   up > mcr_pkg::I64_MAX || up > (mcr_pkg::I64_MAX - anc64)) begin
                  ok_ff <= 1'b0;
                  res_ff <= '0;
               end else begin
                  ok_ff <= 1'b1;
                  res_ff <= anc64 + up;
               end
            end else begin
               ok_ff <= 1'b1;
               if (early_ff) res_ff <= early_val_ff;
               else if (d_ff == 64'd0 || prod_ff[127:64] >= d_ff || quo_ff[63])
                  res_ff <= mcr_pkg::I64_MAX;
               else res_ff <= quo_ff;
            end
         end
         default: ;
      endcase
      if (cmd.save_a)   a_ff   <= res_ff;
      if (cmd.save_b)   b_ff   <= res_ff;
      if (cmd.save_fst) fst_ff <= res_ff;
      if (cmd.save_a && !ok_ff) bad_ff <= 1'b1;
      if (cmd.save_b && !ok_ff) bad_ff <= 1'b1;
   end

   assign sts.busy = (unit_ff != U_IDLE) || cmd.start;
   assign sts.ok   = ok_ff;

   // Response assembly. A deadline needs two or three buffer frames.
   logic       cmd_ok;
   logic [63:0] ans, cnt;
   always_comb begin
      cmd_ok = 1'b0;
      ans    = '0;
      cnt    = '0;
      case (q_ff.cmd) inside
         mcr_pkg::CMD_SLOT_AT, mcr_pkg::CMD_SAMPLE_AT: begin
            cmd_ok = 1'b1;
            ans = res_ff;
         end
         mcr_pkg::CMD_START: begin
            cmd_ok = ok_ff && !bad_ff;
            ans = res_ff;
         end
         mcr_pkg::CMD_DEADLINE: begin
            cmd_ok = ok_ff && !bad_ff && q_ff.buffer_frames[1];
            ans = res_ff;
         end
         mcr_pkg::CMD_RANGE: begin
            cmd_ok = !bad_ff && !fst_ff[63] && (res_ff >= fst_ff);
            ans = fst_ff;
            cnt = res_ff - fst_ff;
         end
         default: cmd_ok = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_value.answer       <= cmd_ok ? ans : 64'd0;
         rsp_value.sample_count <= cmd_ok ? cnt[62:0] : 63'd0;
         rsp_value.status       <= !cmd_ok;
      end
   end

endmodule

[rtl/mcr_ctrl.sv]
// ----------------------------------------------------------------------------
// Media clock rescaler controller
// Sequences the conversions each query needs and runs both handshakes.
// ----------------------------------------------------------------------------
module mcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mcr_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mcr_pkg::dp_cmd_type cmd,
   input  mcr_pkg::dp_sts_type sts
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_C1    = 10'b0000000010,
      S_W1    = 10'b0000000100,
      S_C2    = 10'b0000001000,
      S_W2    = 10'b0000010000,
      S_C3    = 10'b0000100000,
      S_W3    = 10'b0001000000,
      S_C4    = 10'b0010000000,
      S_W4    = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  kind_ff;
   logic [1:0]  bf_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_data.cmd;
         bf_ff   <= req_data.buffer_frames;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.op       = mcr_pkg::OP_START;
      cmd.load     = accept;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_C1;
         S_C1: begin
            cmd.start = 1'b1;
            case (kind_ff)
               mcr_pkg::CMD_SLOT_AT:   begin cmd.op = mcr_pkg::OP_SLOT_AT; state_in = S_W1; end
               mcr_pkg::CMD_SAMPLE_AT: begin cmd.op = mcr_pkg::OP_SAMPLE_AT; state_in = S_W1; end
               mcr_pkg::CMD_START: state_in = S_W1;
               mcr_pkg::CMD_DEADLINE: begin
                  if (bf_ff == 2'd2 || bf_ff == 2'd3) begin
                     cmd.slot_add = bf_ff;
                     state_in = S_W1;
                  end else begin
                     cmd.start = 1'b0;
                     state_in = S_FIN;
                  end
               end
               mcr_pkg::CMD_RANGE: state_in = S_W1;
               default: begin cmd.start = 1'b0; state_in = S_FIN; end
            endcase
         end
         S_W1: if (!sts.busy) begin
            if (kind_ff == mcr_pkg::CMD_RANGE) begin
               cmd.save_a = 1'b1;
               state_in = S_C2;
            end else if (kind_ff == mcr_pkg::CMD_DEADLINE || kind_ff == mcr_pkg::CMD_START) begin
               cmd.save_a = 1'b1;
               state_in = S_FIN;
            end else state_in = S_FIN;
         end
         S_C2: begin
            cmd.start = 1'b1;
            cmd.slot_add = 2'd1;
            state_in = S_W2;
         end
         S_W2: if (!sts.busy) begin
            cmd.save_b = 1'b1;
            state_in = S_C3;
         end
         S_C3: begin
            cmd.start = 1'b1;
            cmd.op = mcr_pkg::OP_SAMPLE_AT;
            cmd.src_start = 1'b1;
            state_in = S_W3;
         end
         S_W3: if (!sts.busy) begin
            cmd.save_fst = 1'b1;
            state_in = S_C4;
         end
         S_C4: begin
            cmd.start = 1'b1;
            cmd.op = mcr_pkg::OP_SAMPLE_AT;
            cmd.src_start = 1'b1;
            cmd.use_b = 1'b1;
            state_in = S_W4;
         end
         S_W4: if (!sts.busy) state_in = S_FIN;
         // The result register is written once the previous response has left.
         S_FIN: if (!rsp_valid_ff || rsp_ready) begin
            cmd.finish = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/media_clock_rescaler.sv]
// ----------------------------------------------------------------------------
// Media clock rescaler
// Answers media-clock queries by exact 64-bit multiply-then-divide.
// ----------------------------------------------------------------------------
//   channel  ports                        direction
//   req      req_valid/ready, req_data    in
//   rsp      rsp_valid/ready, rsp_data    out
//   csr      csr_valid/ready, index/data  in
//
// Each conversion runs setup, four partial products in the multiplier, the
// 64 steps of the divider, post-processing and hand-back; one settled by an
// early check skips the divider. A range query runs four conversions, any
// other query at most one. Reset is synchronous and restores the register
// defaults. A stalled response waits in the output register; the next item
// is taken and computed, then holds in its final state until the response
// leaves.
module media_clock_rescaler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mcr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_data
);

   mcr_pkg::dp_cmd_type cmd;
   mcr_pkg::dp_sts_type sts;

   assign csr_ready = 1'b1;

   mcr_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .sts(sts)
   );

   mcr_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .req_data(req_data), .cmd(cmd), .sts(sts), .rsp_value(rsp_data)
   );

`ifndef SYNTHESIS
   // A waiting response keeps its payload until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("waiting response changed");
   // A failed answer carries zero payload.
   a_zero_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.answer == 64'd0)
      else $error("failed response has nonzero answer");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Media clock rescaler testbench
// Sends directed and random media-clock queries. A local copy of the
// rescaling arithmetic predicts each response. The register settings change
// between phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [63:0] NS_SEC = 64'd1000000000;
   localparam logic [63:0] MAX63  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int          QUIET_LIMIT = 20000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   mcr_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   mcr_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [1:0]       csr_index;
   logic [63:0]      csr_data;

   // Local copy of the register file.
   logic [62:0] anchor;
   logic [19:0] fr_num;
   logic [19:0] fr_den;
   logic [19:0] au_rate;

   mcr_pkg::req_type query_queue[$];
   mcr_pkg::rsp_type answer_queue[$];
   int          errors = 0;
   int          sent = 0;
   int          received = 0;
   int          quiet;
   int          send_wait;
   int          recv_wait;
   int          hold_off;
   bit          hold_request;

   media_clock_rescaler DUT (.*);

   // Clock generator.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Exact floor(a*b/d). Returns 0 when d is zero or the quotient overflows.
   function automatic bit scale_div(input logic [63:0] a, input logic [63:0] b,
                                    input logic [63:0] d, output logic [63:0] q,
                                    output logic [63:0] r);
      logic [127:0] prod;
      logic [127:0] quo;
      prod = a * b;
      q = '0;
      r = '0;
      if (d == 0 || prod[127:64] >= d)
         return 1'b0;
      quo = prod / d;
      q = quo[63:0];
      r = 64'(prod % d);
      return 1'b1;
   endfunction

   // Time to units since the anchor, rounding down.
   function automatic logic [63:0] units_since(input logic [63:0] t, input logic [63:0] rate,
                                               input logic [63:0] period);
      logic [63:0] q;
      logic [63:0] r;
      if (t[63] || t < {1'b0, anchor})
         return '1;
      if (t == {1'b0, anchor})
         return '0;
      if (!scale_div(t - {1'b0, anchor}, rate, period, q, r) || q > MAX63)
         return MAX63;
      return q;
   endfunction

   // Start time of a slot, rounding up.
   function automatic bit start_of_slot(input logic [63:0] slot, output logic [63:0] ns);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] up;
      ns = '0;
      if (slot[63])
         return 1'b0;
      if (!scale_div(slot, NS_SEC * fr_den, {44'd0, fr_num}, q, r))
         return 1'b0;
      up = q + (r != 0);
      if (up < q || up > MAX63 || up > MAX63 - {1'b0, anchor})
         return 1'b0;
      ns = {1'b0, anchor} + up;
      return 1'b1;
   endfunction

   function automatic mcr_pkg::rsp_type predict_answer(input mcr_pkg::req_type q);
      mcr_pkg::rsp_type res;
      logic [63:0] v;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] first;
      logic [63:0] last;
      logic [63:0] ans;
      logic [63:0] cnt;
      bit          ok;
      v = q.query_value;
      ans = '0;
      cnt = '0;
      ok = 1'b1;
      case (q.cmd)
         mcr_pkg::CMD_SLOT_AT: begin
            ans = units_since(v, {44'd0, fr_num}, NS_SEC * fr_den);
         end
         mcr_pkg::CMD_SAMPLE_AT: begin
            ans = units_since(v, {44'd0, au_rate}, NS_SEC);
         end
         mcr_pkg::CMD_START: begin
            ok = start_of_slot(v, ans);
         end
         mcr_pkg::CMD_DEADLINE: begin
            if (v[63] || q.buffer_frames < 2 || v > MAX63 - q.buffer_frames)
               ok = 1'b0;
            else
               ok = start_of_slot(v + q.buffer_frames, ans);
         end
         mcr_pkg::CMD_RANGE: begin
            if (!start_of_slot(v, a) || v == MAX63 || !start_of_slot(v + 1, b)) begin
               ok = 1'b0;
            end else begin
               first = units_since(a, {44'd0, au_rate}, NS_SEC);
               last  = units_since(b, {44'd0, au_rate}, NS_SEC);
               if (first[63] || last < first) begin
                  ok = 1'b0;
               end else begin
                  ans = first;
                  cnt = last - first;
               end
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      if (!ok) begin
         ans = '0;
         cnt = '0;
      end
      res.answer = ans;
      res.sample_count = cnt[62:0];
      res.status = !ok;
      return res;
   endfunction

   // Driver: presents queued items with random gaps; predicts on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         send_wait <= $urandom_range(0, 13);
      end else if (req_valid && req_ready) begin
         answer_queue.push_back(predict_answer(req_data));
         sent <= sent + 1;
         req_valid <= 1'b0;
         send_wait <= $urandom_range(0, 13) * $urandom_range(0, 1);
      end else if (!req_valid && query_queue.size() > 0) begin
         if (send_wait == 0) begin
            req_data <= query_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            send_wait <= send_wait - 1;
         end
      end
   end

   // Monitor: random stalls, a long hold-off on request, field checks.
   always @(posedge clock) begin
      mcr_pkg::rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
         hold_off <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            received <= received + 1;
            if (answer_queue.size() == 0) begin
               $error("response item with nothing expected");
               errors++;
            end else begin
               exp_rsp = answer_queue.pop_front();
               if (rsp_data.answer !== exp_rsp.answer) begin
                  $error("answer: expected %0d actual %0d",
                         $signed(exp_rsp.answer), $signed(rsp_data.answer));
                  errors++;
               end
               if (rsp_data.sample_count !== exp_rsp.sample_count) begin
                  $error("sample_count: expected %0d actual %0d",
                         exp_rsp.sample_count, rsp_data.sample_count);
                  errors++;
               end
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status: expected %0d actual %0d",
                         exp_rsp.status, rsp_data.status);
                  errors++;
               end
            end
         end
         if (hold_request && hold_off == 0) begin
            hold_off <= 3000;
            rsp_ready <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
         end else if (rsp_valid && rsp_ready) begin
            recv_wait <= $urandom_range(0, 13) * $urandom_range(0, 1);
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no accepted item.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mcr_pkg::REG_ANCHOR: anchor  = value[62:0];
         mcr_pkg::REG_NUM:    fr_num  = value[19:0];
         mcr_pkg::REG_DEN:    fr_den  = value[19:0];
         default:             au_rate = value[19:0];
      endcase
   endtask

   task automatic push_query(input logic [2:0] c, input logic [63:0] v, input logic [1:0] bf);
      mcr_pkg::req_type q;
      q.cmd = c;
      q.query_value = v;
      q.buffer_frames = bf;
      query_queue.push_back(q);
   endtask

   // Wait until every queued item is sent and answered, then let the block settle.
   task automatic drain();
      while (query_queue.size() > 0 || req_valid || answer_queue.size() > 0)
         @(posedge clock);
      repeat (320) @(posedge clock);
   endtask

   // Random query with values mostly near the scale of the current setting.
   task automatic random_query();
      logic [63:0] v;
      logic [2:0]  c;
      c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = 64'($urandom_range(0, 1000));
         2: v = {1'b0, anchor} + {32'd0, $urandom} * $urandom_range(1, 1000);
         3: v = {1'b0, anchor} - 64'($urandom_range(0, 5));
         4: v = MAX63 - 64'($urandom_range(0, 3));
         default: v = 64'($urandom) * 64'($urandom_range(0, 1 << 20));
      endcase
      push_query(c, v, 2'($urandom_range(0, 3)));
   endtask

   task automatic directed_set();
      push_query(mcr_pkg::CMD_SLOT_AT,   {1'b0, anchor} + 64'd1000000000, 2'd0);
      push_query(mcr_pkg::CMD_SLOT_AT,   {1'b0, anchor} - 64'd1, 2'd0);
      push_query(mcr_pkg::CMD_SLOT_AT,   MAX63, 2'd0);
      push_query(mcr_pkg::CMD_SLOT_AT,   64'h8000_0000_0000_0000, 2'd0);
      push_query(mcr_pkg::CMD_SAMPLE_AT, {1'b0, anchor}, 2'd0);
      push_query(mcr_pkg::CMD_SAMPLE_AT, MAX63, 2'd1);
      push_query(mcr_pkg::CMD_SAMPLE_AT, {1'b0, anchor} + 64'd12345678, 2'd0);
      push_query(mcr_pkg::CMD_START,     64'd0, 2'd0);
      push_query(mcr_pkg::CMD_START,     64'd7, 2'd0);
      push_query(mcr_pkg::CMD_START,     '1, 2'd0);
      push_query(mcr_pkg::CMD_START,     MAX63, 2'd0);
      push_query(mcr_pkg::CMD_DEADLINE,  64'd5, 2'd2);
      push_query(mcr_pkg::CMD_DEADLINE,  64'd5, 2'd3);
      push_query(mcr_pkg::CMD_DEADLINE,  64'd5, 2'd0);
      push_query(mcr_pkg::CMD_DEADLINE,  64'd5, 2'd1);
      push_query(mcr_pkg::CMD_DEADLINE,  MAX63 - 64'd1, 2'd3);
      push_query(mcr_pkg::CMD_RANGE,     64'd0, 2'd0);
      push_query(mcr_pkg::CMD_RANGE,     64'd1001, 2'd0);
      push_query(mcr_pkg::CMD_RANGE,     MAX63, 2'd0);
      push_query(mcr_pkg::CMD_RANGE,     64'h8000_0000_0000_0001, 2'd0);
      push_query(3'd5, 64'd1, 2'd2);
      push_query(3'd7, '1, 2'd3);
   endtask

   // Stimulus phases with different register settings.
   initial begin
      hold_request = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = mcr_pkg::REG_ANCHOR;
      csr_data = '0;
      anchor = '0;
      fr_num = 20'd30;
      fr_den = 20'd1;
      au_rate = 20'd48000;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults.
      directed_set();
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(mcr_pkg::REG_ANCHOR, 64'd1000000000000);
               write_reg(mcr_pkg::REG_NUM, 64'd30000);
               write_reg(mcr_pkg::REG_DEN, 64'd1001);
               write_reg(mcr_pkg::REG_AUDIO, 64'd44100);
            end
            1: begin
               write_reg(mcr_pkg::REG_NUM, 64'd0);
               write_reg(mcr_pkg::REG_DEN, 64'd0);
               write_reg(mcr_pkg::REG_AUDIO, 64'hFFFF_FFFF_FFF0_0001);
            end
            2: begin
               write_reg(mcr_pkg::REG_ANCHOR, MAX63);
               write_reg(mcr_pkg::REG_NUM, 64'd1);
               write_reg(mcr_pkg::REG_DEN, 64'd1000000);
               write_reg(mcr_pkg::REG_AUDIO, 64'd1);
            end
            3: begin
               write_reg(mcr_pkg::REG_ANCHOR, '1);
               write_reg(mcr_pkg::REG_NUM, 64'hFFFFF);
               write_reg(mcr_pkg::REG_DEN, 64'hFFFFF);
               write_reg(mcr_pkg::REG_AUDIO, 64'hFFFFF);
            end
            4: begin
               write_reg(mcr_pkg::REG_ANCHOR, {$urandom, $urandom} >> 20);
               write_reg(mcr_pkg::REG_NUM, 64'd1000000);
               write_reg(mcr_pkg::REG_DEN, 64'd1);
               write_reg(mcr_pkg::REG_AUDIO, 64'd1000000);
            end
            default: begin
               write_reg(mcr_pkg::REG_ANCHOR, 64'd0);
               write_reg(mcr_pkg::REG_NUM, 64'($urandom_range(1, 120)));
               write_reg(mcr_pkg::REG_DEN, 64'($urandom_range(1, 1001)));
               write_reg(mcr_pkg::REG_AUDIO, 64'($urandom_range(8000, 192000)));
            end
         endcase
         if (phase < 2)
            directed_set();
         for (int n = 0; n < 100; n++)
            random_query();
         // Long receiver hold-off while queries keep coming.
         if (phase == 0) begin
            hold_request = 1;
            wait (hold_off != 0);
            hold_request = 0;
         end
         drain();
      end

      $display("Covered %0d queries (%0d responses) over seven register settings,",
               sent, received);
      $display("including reset defaults, zero rates, extreme anchors and a long stall.");
      if (errors == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule

[filelist.f]
rtl/mcr_pkg.sv
rtl/mcr_datapath.sv
rtl/mcr_ctrl.sv
rtl/media_clock_rescaler.sv
verif/testbench.sv
